### hdl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
`default_nettype none

package dq_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW         = $clog2(DEPTH + 1);

  // Port field widths
  localparam int ACTION_W = 3;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [AW-1:0] ptr_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5,
    ACT_GET        = 3'd6,
    ACT_NONE       = 3'd7
  } dq_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_e;

  // Controller to datapath
  typedef struct packed {
    logic take;  // input beat accepted this cycle
    logic load;  // move pending result into the output register
  } dq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_room;  // output register free or being drained this cycle
  } dq_sts_t;

endpackage

`default_nettype wire

### hdl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dq_ram #(
  parameter int DATA_W    = 32,
  parameter int NUM_WORDS = 16,
  parameter int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [NUM_WORDS];
  logic [DATA_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hdl/dq_ctrl.sv
// Controller state machine for the double-ended queue.
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output dq_cmd_t      cmd_o,
  input  wire dq_sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } dq_state_e;

  dq_state_e state_q, state_d;

  // Take a beat only in idle; finish it once the output register has room
  always_comb begin
    state_d    = state_q;
    cmd_o.take = 1'b0;
    cmd_o.load = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        if (sts_i.out_room) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_take_then_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> state_q == S_READ)
    else $error("accepted beat did not move to read state");
  a_wait_for_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && !sts_i.out_room) |=> state_q == S_READ)
    else $error("left read state without output room");
  a_stall_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> in_stall_o)
    else $error("input open while a beat is in flight");
`endif

endmodule

`default_nettype wire

### hdl/dq_datapath.sv
// Datapath: ring pointers, count, ring store and output register.
`default_nettype none

module dq_datapath
  import dq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dq_cmd_t             cmd_i,
  output dq_sts_t                  sts_o,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic [DATA_W-1:0]   data_word_i,
  input  wire logic [INDEX_W-1:0]  index_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [DATA_W-1:0]        result_word_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [COUNT_W-1:0]       count_o
);

  localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

  ptr_t front_q, front_d;
  ptr_t back_q, back_d;
  cnt_t count_q, count_d;

  dq_status_e pend_status_q, pend_status_d;
  logic       pend_use_q, pend_use_d;

  logic                  out_valid_q;
  logic [DATA_W-1:0]     out_word_q;
  dq_status_e            out_status_q;
  logic [COUNT_W-1:0]    out_count_q;

  logic                  is_full, no_words, idx_ok;
  logic [AW:0]           get_sum;
  ptr_t                  get_ptr;
  ptr_t                  front_dec, back_inc, front_inc, back_dec;
  logic                  wr_en, rd_en;
  ptr_t                  wr_addr, rd_addr;
  logic [WORD_WIDTH-1:0] rd_data;

  // Ring arithmetic
  assign is_full   = (count_q == cnt_t'(DEPTH));
  assign no_words  = (count_q == '0);
  assign idx_ok    = (CMP_W'(index_i) < CMP_W'(count_q));
  assign front_dec = (front_q == '0) ? ptr_t'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == ptr_t'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign back_inc  = (back_q == ptr_t'(DEPTH - 1)) ? '0 : back_q + 1'b1;
  assign back_dec  = (back_q == '0) ? ptr_t'(DEPTH - 1) : back_q - 1'b1;
  assign get_sum   = {1'b0, front_q} + (AW + 1)'(index_i);
  assign get_ptr   = (get_sum >= (AW + 1)'(DEPTH)) ? AW'(get_sum - (AW + 1)'(DEPTH))
                                                    : AW'(get_sum);

  // Action decode on an accepted beat
  always_comb begin
    front_d       = front_q;
    back_d        = back_q;
    count_d       = count_q;
    pend_status_d = pend_status_q;
    pend_use_d    = pend_use_q;
    wr_en         = 1'b0;
    wr_addr       = front_dec;
    rd_en         = 1'b0;
    rd_addr       = front_q;
    if (cmd_i.take) begin
      pend_status_d = ST_OK;
      pend_use_d    = 1'b0;
      unique case (dq_action_e'(action_i))
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (is_full) begin
            pend_status_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
            if (dq_action_e'(action_i) == ACT_PUSH_FRONT) begin
              wr_addr = front_dec;
              front_d = front_dec;
            end else begin
              wr_addr = back_inc;
              back_d  = back_inc;
            end
          end
        end
        ACT_POP_FRONT, ACT_PEEK_FRONT: begin
          if (no_words) begin
            pend_status_d = ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = front_q;
            pend_use_d = 1'b1;
            if (dq_action_e'(action_i) == ACT_POP_FRONT) begin
              front_d = front_inc;
              count_d = count_q - 1'b1;
            end
          end
        end
        ACT_POP_BACK, ACT_PEEK_BACK: begin
          if (no_words) begin
            pend_status_d = ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = back_q;
            pend_use_d = 1'b1;
            if (dq_action_e'(action_i) == ACT_POP_BACK) begin
              back_d  = back_dec;
              count_d = count_q - 1'b1;
            end
          end
        end
        ACT_GET: begin
          if (!idx_ok) begin
            pend_status_d = ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = get_ptr;
            pend_use_d = 1'b1;
          end
        end
        default: begin
          pend_status_d = ST_OK;
        end
      endcase
    end
  end

  // Ring store
  dq_ram #(
    .DATA_W    (WORD_WIDTH),
    .NUM_WORDS (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (WORD_WIDTH'(data_word_i)),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Pointer and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= ptr_t'(DEPTH - 1);
      count_q <= '0;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  // Pending result info for the beat in flight
  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    pend_use_q    <= pend_use_d;
  end

  // Output register
  assign sts_o.out_room = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_word_q   <= pend_use_q ? DATA_W'(rd_data) : '0;
      out_status_q <= pend_status_q;
      out_count_q  <= COUNT_W'(count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_word_o = out_word_q;
  assign status_o      = out_status_q;
  assign count_o       = out_count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(DEPTH))
    else $error("count above depth");
  a_full_push_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && is_full && (action_i == ACT_PUSH_FRONT || action_i == ACT_PUSH_BACK))
    |=> $stable(count_q) && $stable(front_q) && $stable(back_q))
    else $error("push into full store changed state");
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.load))
    else $error("output beat without a load");
`endif

endmodule

`default_nettype wire

### hdl/double_ended_queue.sv
// Double-ended queue top level: controller plus datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one action per beat:
//   push front, push back, pop front, pop back, peek front, peek back or
//   get at an index counted from the front; code seven does nothing.
//   Output channel (out_valid_o / out_stall_i) returns exactly one beat per
//   input beat: result word, status (ok, empty or bad index, full) and the
//   count after the action. A push into a full store is dropped.
//   Each input beat is taken in idle; its ring store read data and pending
//   status are registered, and the result is loaded into the output register
//   once that register has room. The controller takes a new beat only from
//   idle, so it accepts no further beat until the last result is loaded.
//   Reset (rst_ni low, asynchronous): store empty, front at 0, back at
//   DEPTH-1, no output beat pending. Store contents are not cleared.
//   When out_stall_i holds a result, one more beat can be accepted; its
//   result waits in the RAM read register and the input then stalls.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic [DATA_W-1:0]   data_word_i,
  input  wire logic [INDEX_W-1:0]  index_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [DATA_W-1:0]        result_word_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [COUNT_W-1:0]       count_o
);

  dq_cmd_t cmd;
  dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .data_word_i   (data_word_i),
    .index_i       (index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_word_o (result_word_o),
    .status_o      (status_o),
    .count_o       (count_o)
  );

endmodule

`default_nettype wire
